[hw/rtl/vpa_pkg.sv]
// Shared types and constants for the variable partition allocator.
`timescale 1ns / 1ps
`default_nettype none
package vpa_pkg;

  localparam int unsigned MemSize = 1024;
  localparam int unsigned AddrW   = 10;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned OwnerW  = 8;

  localparam logic [1:0] CMD_FIRST = 2'd0;
  localparam logic [1:0] CMD_BEST  = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;
  localparam logic [1:0] CMD_FREE  = 2'd3;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_NOFIT   = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_NOOWNER = 3'd3;
  localparam logic [2:0] STAT_BADSIZE = 3'd4;

  typedef struct packed {
    logic [AddrW-1:0]  start;
    logic [SizeW-1:0]  size;
    logic [OwnerW-1:0] owner;
    logic              busy;
  } part_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_SPLIT,
    S_MARK,
    S_FREE,
    S_MRGR,
    S_REM,
    S_MRGL,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

[hw/rtl/variable_partition_allocator_core.sv]
// Variable partition allocator: partition table and request sequencer.
// A bad size goes straight to the result; otherwise the table scan visits one entry a cycle
// and each split or merge moves one entry a cycle.
// Throughput: one request at a time; busy stays high through the result strobe.
// The result is shown for one cycle on result_valid_o; the receiver cannot stall.
// Reset: the table holds one free partition covering the whole memory, cursor zero.
`timescale 1ns / 1ps
`default_nettype none
module variable_partition_allocator_core
  import vpa_pkg::*;
#(
  parameter int unsigned MAX_PARTS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [OwnerW-1:0] owner_id_i,
  input  wire logic [SizeW-1:0]  request_size_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic [AddrW-1:0]       block_address_o,
  output logic [SizeW-1:0]       block_size_o
);

  localparam int unsigned IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);

  state_e state_q, state_d;
  part_t  part_q [MAX_PARTS];
  logic [CW-1:0] count_q, count_d, k_q, k_d;
  logic [IW-1:0] cursor_q, cursor_d, scan_q, scan_d, pick_q, pick_d, j_q, j_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [OwnerW-1:0] owner_q, owner_d;
  logic [SizeW-1:0]  req_q, req_d, best_q, best_d, msz_q, msz_d;
  logic              found_q, found_d, left_q, left_d;
  logic [2:0]        stat_q, stat_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [SizeW-1:0]  bsz_q, bsz_d;

  logic [IW-1:0] rd_idx, wr_idx;
  logic          wr_en;
  part_t         rd_e, wr_e;
  logic          fit, match, better, last, hit;
  logic [CW-1:0] scan_nx, newcnt, cur_c;

  always_comb begin
    case (state_q)
      S_SCAN:  rd_idx = scan_q;
      S_SHIFT: rd_idx = j_q;
      S_MRGR:  rd_idx = IW'(pick_q + 1'b1);
      S_REM:   rd_idx = IW'(j_q + 1'b1);
      S_MRGL:  rd_idx = IW'(pick_q - 1'b1);
      default: rd_idx = pick_q;
    endcase
  end
  assign rd_e = part_q[rd_idx];

  assign fit     = !rd_e.busy && (rd_e.size >= req_q);
  assign match   = rd_e.busy && (rd_e.owner == owner_q);
  assign better  = fit && (!found_q || (rd_e.size < best_q));
  assign last    = (k_q == CW'(count_q - 1'b1));
  assign hit     = (cmd_q == CMD_FREE) ? match : ((cmd_q != CMD_BEST) && fit);
  assign scan_nx = CW'(scan_q) + 1'b1;
  assign newcnt  = CW'(count_q - 1'b1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if ((cmd_i != CMD_FREE) &&
              ((request_size_i == '0) || (request_size_i > SizeW'(MemSize)))) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (cmd_q == CMD_FREE) ? S_FREE : S_DECIDE;
        end else if (last) begin
          state_d = ((cmd_q == CMD_BEST) && (found_q || better)) ? S_DECIDE : S_DONE;
        end
      end
      S_DECIDE: begin
        if (rd_e.size == req_q) begin
          state_d = S_MARK;
        end else if (count_q >= CW'(MAX_PARTS)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (j_q <= pick_q) begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: state_d = S_MARK;
      S_MARK:  state_d = S_DONE;
      S_FREE:  state_d = S_MRGR;
      S_MRGR: begin
        if ((CW'(pick_q) + 1'b1 < count_q) && !rd_e.busy) begin
          state_d = S_REM;
        end else begin
          state_d = S_MRGL;
        end
      end
      S_REM: begin
        if (!(CW'(j_q) + 1'b1 < count_q)) begin
          state_d = left_q ? S_DONE : S_MRGL;
        end
      end
      S_MRGL: begin
        if ((pick_q != '0) && !rd_e.busy) begin
          state_d = S_REM;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    k_d      = k_q;
    scan_d   = scan_q;
    pick_d   = pick_q;
    j_d      = j_q;
    cmd_d    = cmd_q;
    owner_d  = owner_q;
    req_d    = req_q;
    best_d   = best_q;
    msz_d    = msz_q;
    found_d  = found_q;
    left_d   = left_q;
    stat_d   = stat_q;
    addr_d   = addr_q;
    bsz_d    = bsz_q;
    wr_en    = 1'b0;
    wr_idx   = pick_q;
    wr_e     = rd_e;
    cur_c    = CW'(cursor_q);
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          owner_d = owner_id_i;
          req_d   = request_size_i;
          k_d     = '0;
          found_d = 1'b0;
          left_d  = 1'b0;
          scan_d  = (cmd_i == CMD_NEXT) ? cursor_q : '0;
          stat_d  = STAT_BADSIZE;
          addr_d  = '0;
          bsz_d   = '0;
        end
      end
      S_SCAN: begin
        k_d    = k_q + 1'b1;
        scan_d = (scan_nx >= count_q) ? '0 : IW'(scan_nx);
        if (hit || better) begin
          pick_d  = scan_q;
          best_d  = rd_e.size;
          found_d = 1'b1;
        end
        stat_d = (cmd_q == CMD_FREE) ? STAT_NOOWNER : STAT_NOFIT;
      end
      S_DECIDE: begin
        stat_d = STAT_FULL;
        j_d    = IW'(count_q - 1'b1);
      end
      S_SHIFT: begin
        if (j_q > pick_q) begin
          wr_en  = 1'b1;
          wr_idx = IW'(j_q + 1'b1);
          j_d    = IW'(j_q - 1'b1);
        end
      end
      S_SPLIT: begin
        wr_en      = 1'b1;
        wr_idx     = IW'(pick_q + 1'b1);
        wr_e.start = AddrW'(rd_e.start + req_q);
        wr_e.size  = rd_e.size - req_q;
        wr_e.owner = '0;
        wr_e.busy  = 1'b0;
        count_d    = count_q + 1'b1;
      end
      S_MARK: begin
        wr_en      = 1'b1;
        wr_e.size  = req_q;
        wr_e.owner = owner_q;
        wr_e.busy  = 1'b1;
        stat_d     = STAT_OK;
        addr_d     = rd_e.start;
        bsz_d      = req_q;
        cursor_d   = (CW'(pick_q) + 1'b1 >= count_q) ? '0 : IW'(pick_q + 1'b1);
      end
      S_FREE: begin
        wr_en      = 1'b1;
        wr_e.owner = '0;
        wr_e.busy  = 1'b0;
        stat_d     = STAT_OK;
        addr_d     = rd_e.start;
        bsz_d      = rd_e.size;
        msz_d      = rd_e.size;
      end
      S_MRGR: begin
        if ((CW'(pick_q) + 1'b1 < count_q) && !rd_e.busy) begin
          wr_en      = 1'b1;
          wr_idx     = pick_q;
          wr_e.start = addr_q;
          wr_e.size  = msz_q + rd_e.size;
          wr_e.owner = '0;
          wr_e.busy  = 1'b0;
          msz_d      = msz_q + rd_e.size;
          pick_d     = pick_q;
          j_d        = IW'(pick_q + 1'b1);
        end
      end
      S_REM: begin
        if (CW'(j_q) + 1'b1 < count_q) begin
          wr_en  = 1'b1;
          wr_idx = j_q;
          j_d    = IW'(j_q + 1'b1);
        end else begin
          count_d = newcnt;
          if ((cursor_q >= (left_q ? pick_q : IW'(pick_q + 1'b1))) && (cursor_q != '0)) begin
            cur_c = CW'(cursor_q) - 1'b1;
          end
          cursor_d = (cur_c >= newcnt) ? '0 : IW'(cur_c);
        end
      end
      S_MRGL: begin
        if ((pick_q != '0) && !rd_e.busy) begin
          wr_en     = 1'b1;
          wr_idx    = IW'(pick_q - 1'b1);
          wr_e.size = rd_e.size + msz_q;
          left_d    = 1'b1;
          j_d       = pick_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= CW'(1);
      cursor_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q[0] <= '{start: '0, size: SizeW'(MemSize), owner: '0, busy: 1'b0};
    end else if (wr_en) begin
      part_q[wr_idx] <= wr_e;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    scan_q  <= scan_d;
    pick_q  <= pick_d;
    j_q     <= j_d;
    cmd_q   <= cmd_d;
    owner_q <= owner_d;
    req_q   <= req_d;
    best_q  <= best_d;
    msz_q   <= msz_d;
    found_q <= found_d;
    left_q  <= left_d;
    stat_q  <= stat_d;
    addr_q  <= addr_d;
    bsz_q   <= bsz_d;
  end

  always_comb begin
    busy            = (state_q != S_IDLE);
    result_valid_o  = (state_q == S_DONE);
    status_o        = stat_q;
    block_address_o = addr_q;
    block_size_o    = bsz_q;
  end

endmodule
`default_nettype wire

[tb/tb_variable_partition_allocator_core.sv]
// Self-checking testbench for the variable partition allocator core.
`timescale 1ns / 1ps
module tb_variable_partition_allocator_core;
  import vpa_pkg::*;

  localparam int NParts = 32;
  localparam int NRand = 900;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd_i = CMD_FIRST;
  logic [OwnerW-1:0] owner_id_i = '0;
  logic [SizeW-1:0] request_size_i = '0;
  logic result_valid_o;
  logic [2:0] status_o;
  logic [AddrW-1:0] block_address_o;
  logic [SizeW-1:0] block_size_o;

  variable_partition_allocator_core #(.MAX_PARTS(NParts)) dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .owner_id_i, .request_size_i,
    .result_valid_o, .status_o, .block_address_o, .block_size_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
  } alloc_res_t;

  typedef struct {
    logic [1:0]        cmd;
    logic [OwnerW-1:0] owner;
    logic [SizeW-1:0]  req;
    bit                typed;
    alloc_res_t        res;
  } row_t;

  int unsigned p_start[NParts];
  int unsigned p_size[NParts];
  int unsigned p_owner[NParts];
  bit          p_busy[NParts];
  int unsigned p_count;
  int unsigned cursor;

  alloc_res_t expected_q[$];
  int errors = 0;
  int n_ok = 0;
  int n_fail = 0;
  int cycles = 0;
  int send_idle = 17;

  function automatic void table_reset();
    for (int i = 0; i < NParts; i++) begin
      p_start[i] = 0; p_size[i] = 0; p_owner[i] = 0; p_busy[i] = 0;
    end
    p_size[0] = MemSize;
    p_count = 1;
    cursor = 0;
  endfunction

  function automatic void drop_entry(int unsigned r);
    for (int unsigned i = r; i + 1 < p_count; i++) begin
      p_start[i] = p_start[i+1]; p_size[i] = p_size[i+1];
      p_owner[i] = p_owner[i+1]; p_busy[i] = p_busy[i+1];
    end
    p_count--;
    p_start[p_count] = 0; p_size[p_count] = 0;
    p_owner[p_count] = 0; p_busy[p_count] = 0;
    if (cursor >= r && cursor > 0) cursor--;
    if (cursor >= p_count) cursor = 0;
  endfunction

  function automatic alloc_res_t predict_alloc(logic [1:0] cmd, int unsigned owner,
                                               int unsigned req);
    alloc_res_t r;
    int unsigned pick, idx, j;
    bit found;
    r = '0;
    pick = 0;
    idx = 0;
    found = 0;
    if (cmd == CMD_FREE) begin
      for (int unsigned i = 0; i < p_count && !found; i++)
        if (p_busy[i] && p_owner[i] == owner) begin idx = i; found = 1; end
      if (!found) begin
        r.status = STAT_NOOWNER;
        return r;
      end
      r.status = STAT_OK; r.addr = AddrW'(p_start[idx]); r.size = SizeW'(p_size[idx]);
      p_busy[idx] = 0; p_owner[idx] = 0;
      if (idx + 1 < p_count && !p_busy[idx+1]) begin
        p_size[idx] += p_size[idx+1];
        drop_entry(idx + 1);
      end
      if (idx > 0 && !p_busy[idx-1]) begin
        p_size[idx-1] += p_size[idx];
        drop_entry(idx);
      end
      return r;
    end
    if (req == 0 || req > MemSize) begin
      r.status = STAT_BADSIZE;
      return r;
    end
    if (cmd == CMD_FIRST) begin
      for (int unsigned i = 0; i < p_count && !found; i++)
        if (!p_busy[i] && p_size[i] >= req) begin pick = i; found = 1; end
    end else if (cmd == CMD_BEST) begin
      for (int unsigned i = 0; i < p_count; i++)
        if (!p_busy[i] && p_size[i] >= req && (!found || p_size[i] < p_size[pick])) begin
          pick = i; found = 1;
        end
    end else begin
      j = cursor;
      for (int unsigned k = 0; k < p_count && !found; k++) begin
        if (j >= p_count) j = 0;
        if (!p_busy[j] && p_size[j] >= req) begin pick = j; found = 1; end
        j++;
      end
    end
    if (!found) begin
      r.status = STAT_NOFIT;
      return r;
    end
    if (p_size[pick] != req) begin
      if (p_count >= NParts) begin
        r.status = STAT_FULL;
        return r;
      end
      for (int unsigned i = p_count; i > pick + 1; i--) begin
        p_start[i] = p_start[i-1]; p_size[i] = p_size[i-1];
        p_owner[i] = p_owner[i-1]; p_busy[i] = p_busy[i-1];
      end
      p_start[pick+1] = p_start[pick] + req;
      p_size[pick+1] = p_size[pick] - req;
      p_owner[pick+1] = 0; p_busy[pick+1] = 0;
      p_count++;
      p_size[pick] = req;
    end
    p_busy[pick] = 1;
    p_owner[pick] = owner;
    cursor = pick + 1;
    if (cursor >= p_count) cursor = 0;
    r.status = STAT_OK; r.addr = AddrW'(p_start[pick]); r.size = SizeW'(req);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("tb_variable_partition_allocator_core NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result st=%0d addr=%0d size=%0d", $time, status_o,
                 block_address_o, block_size_o);
        errors++;
      end else begin
        alloc_res_t e;
        e = expected_q.pop_front();
        if (e.status == STAT_OK) n_ok++; else n_fail++;
        if (status_o !== e.status) begin
          $display("%0t status exp=%0d act=%0d", $time, e.status, status_o); errors++;
        end
        if (block_address_o !== e.addr) begin
          $display("%0t address exp=%0d act=%0d", $time, e.addr, block_address_o);
          errors++;
        end
        if (block_size_o !== e.size) begin
          $display("%0t size exp=%0d act=%0d", $time, e.size, block_size_o); errors++;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [OwnerW-1:0] owner, logic [SizeW-1:0] req,
                           bit typed, alloc_res_t typed_res);
    alloc_res_t p;
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    owner_id_i <= owner;
    request_size_i <= req;
    do @(posedge clk_i); while (busy);
    p = predict_alloc(cmd, 32'(owner), 32'(req));
    if (typed && p != typed_res) begin
      $display("%0t directed row exp=%h predictor=%h", $time, typed_res, p);
      errors++;
    end
    expected_q.push_back(p);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic row_t mk(logic [1:0] c, int o, int q, bit t = 0,
                              logic [2:0] s = 0, int a = 0, int z = 0);
    row_t r;
    r.cmd = c; r.owner = OwnerW'(o); r.req = SizeW'(q); r.typed = t;
    r.res.status = s; r.res.addr = AddrW'(a); r.res.size = SizeW'(z);
    return r;
  endfunction

  row_t rows[$];
  logic [1:0] rc;
  int unsigned rq;

  initial begin
    table_reset();
    rows.push_back(mk(CMD_FREE, 5, 0, 1, STAT_NOOWNER));
    rows.push_back(mk(CMD_FIRST, 1, 0, 1, STAT_BADSIZE));
    rows.push_back(mk(CMD_BEST, 1, 1025, 1, STAT_BADSIZE));
    rows.push_back(mk(CMD_NEXT, 1, 2047, 1, STAT_BADSIZE));
    rows.push_back(mk(CMD_FIRST, 255, 1024, 1, STAT_OK, 0, 1024));
    rows.push_back(mk(CMD_BEST, 2, 1, 1, STAT_NOFIT));
    rows.push_back(mk(CMD_FREE, 255, 0, 1, STAT_OK, 0, 1024));
    rows.push_back(mk(CMD_FIRST, 0, 100, 1, STAT_OK, 0, 100));
    rows.push_back(mk(CMD_FIRST, 1, 200));
    rows.push_back(mk(CMD_FIRST, 2, 50));
    rows.push_back(mk(CMD_FIRST, 3, 300));
    rows.push_back(mk(CMD_FREE, 1, 0));
    rows.push_back(mk(CMD_FREE, 3, 0));
    rows.push_back(mk(CMD_BEST, 4, 40));
    rows.push_back(mk(CMD_NEXT, 5, 10));
    rows.push_back(mk(CMD_NEXT, 6, 600));
    rows.push_back(mk(CMD_NEXT, 7, 5));
    rows.push_back(mk(CMD_FREE, 2, 0));
    rows.push_back(mk(CMD_FREE, 0, 0));
    for (int i = 0; i < 32; i++) rows.push_back(mk(CMD_NEXT, 8 + i % 4, 1));
    rows.push_back(mk(CMD_FREE, 9, 0));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].cmd, rows[i].owner, rows[i].req, rows[i].typed,
                                rows[i].res);
    for (int n = 0; n < NRand; n++) begin
      if (n == NRand / 3) send_idle = 72;
      if (n == 2 * NRand / 3) send_idle = 0;
      if (n == NRand / 2) begin
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
      end
      rc = 2'($urandom_range(3));
      case ($urandom_range(9))
        0: rq = $urandom_range(2047);
        1: rq = $urandom_range(1024, 256);
        default: rq = $urandom_range(64, 1);
      endcase
      send_item(rc, OwnerW'($urandom_range(15) == 0 ? $urandom_range(255) : $urandom_range(7)),
                SizeW'(rq), 0, '0);
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3 * NParts + 10) @(posedge clk_i);
    $display("Covered %0d items: %0d ok results, %0d refused, all three fit policies and free.",
             rows.size() + NRand, n_ok, n_fail);
    if (errors == 0) begin
      $display("tb_variable_partition_allocator_core OK");
    end else begin
      $display("tb_variable_partition_allocator_core NOT OK");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/vpa_pkg.sv
hw/rtl/variable_partition_allocator_core.sv
tb/tb_variable_partition_allocator_core.sv
